### hdl/sph_harmonic_diag_operator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spherical-harmonic diagonal operator
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SPH_HARMONIC_DIAG_OPERATOR_ASSERT_SVH
`define SPH_HARMONIC_DIAG_OPERATOR_ASSERT_SVH

// same-cycle implication
`define SHD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shd assertion failed");

// next-cycle implication
`define SHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shd assertion failed");

`endif

### hdl/shd_pkg.sv
// ----------------------------------------------------------------------------
// shd_pkg
// Types and constants shared by the spherical-harmonic diagonal operator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shd_pkg;

    localparam int DEG_W  = 6;
    localparam int ORD_W  = 7;
    localparam int KMAG_W = 12;   // |l(l+1)| <= 4032

    localparam logic [1:0] REG_DEGREE_LIMIT = 2'd0;
    localparam logic [1:0] REG_ZONAL_ONLY   = 2'd1;
    localparam logic [1:0] REG_OPERATION    = 2'd2;

    typedef enum logic [1:0] {
        OP_AZIMUTH     = 2'd0,
        OP_LAPLACE     = 2'd1,
        OP_INV_LAPLACE = 2'd2,
        OP_PASS        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic div;
        logic zero;
        logic kbit;
    } lane_ctrl_t;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic [ORD_W-1:0] order;
        logic             last;
    } idx_tag_t;

endpackage

### hdl/shd_lane.sv
// ----------------------------------------------------------------------------
// shd_lane
// One arithmetic lane: shift-add multiply with saturation, or restoring
// divide, one step per cycle on a single shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shd_lane #(
    parameter int COEFF_WIDTH = 32
) (
    input  logic                             clk,
    input  shd_pkg::lane_ctrl_t              ctrl,
    input  logic signed [COEFF_WIDTH-1:0]    x,
    input  logic                             kneg,
    input  logic [shd_pkg::KMAG_W-1:0]       kmag,
    output logic signed [COEFF_WIDTH-1:0]    result,
    output logic                             sat
);

    localparam int KW = shd_pkg::KMAG_W;
    localparam int AW = COEFF_WIDTH + KW;
    localparam logic [AW-1:0] HALF = AW'(1) << (COEFF_WIDTH - 1);
    localparam logic [COEFF_WIDTH-1:0] HI = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
    localparam logic [COEFF_WIDTH-1:0] LO = {1'b1, {(COEFF_WIDTH-1){1'b0}}};

    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] sh_reg, sh_next;
    logic          xneg_reg, kneg_reg, div_reg, zero_reg;

    logic [COEFF_WIDTH-1:0] x_u, xmag;
    logic [KW:0]            rem_sh;
    logic [AW-1:0]          op_a, op_b, sum;
    logic                   cin, fits, neg;
    logic [COEFF_WIDTH-1:0] q;

    assign x_u    = x;
    assign xmag   = x_u[COEFF_WIDTH-1] ? (~x_u + 1'b1) : x_u;
    assign rem_sh = {acc_reg[KW-1:0], sh_reg[COEFF_WIDTH-1]};

    // shared adder: accumulate in multiply, trial subtract in divide
    always_comb
    begin
        if (div_reg)
        begin
            op_a = AW'(rem_sh);
            op_b = ~AW'(kmag);
            cin  = 1'b1;
        end
        else
        begin
            op_a = acc_reg;
            op_b = ctrl.kbit ? sh_reg : '0;
            cin  = 1'b0;
        end
    end

    assign sum  = op_a + op_b + AW'(cin);
    assign fits = !sum[AW-1];

    always_comb
    begin
        acc_next = acc_reg;
        sh_next  = sh_reg;
        if (ctrl.load)
        begin
            acc_next = '0;
            sh_next  = AW'(xmag);
        end
        else if (ctrl.step)
        begin
            if (div_reg)
            begin
                acc_next = fits ? sum : AW'(rem_sh);
                sh_next  = {sh_reg[AW-2:0], fits};
            end
            else
            begin
                acc_next = sum;
                sh_next  = sh_reg << 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        if (ctrl.load)
        begin
            xneg_reg <= x_u[COEFF_WIDTH-1];
            kneg_reg <= kneg;
            div_reg  <= ctrl.div;
            zero_reg <= ctrl.zero;
        end
    end

    assign neg = xneg_reg ^ kneg_reg;
    assign q   = sh_reg[COEFF_WIDTH-1:0];

    always_comb
    begin
        sat    = 1'b0;
        result = '0;
        if (zero_reg)
        begin
            result = '0;
        end
        else if (div_reg)
        begin
            // out = -(x / k), k > 0
            result = xneg_reg ? q : (~q + 1'b1);
        end
        else if (!neg)
        begin
            sat    = acc_reg >= HALF;
            result = sat ? HI : acc_reg[COEFF_WIDTH-1:0];
        end
        else
        begin
            sat    = acc_reg > HALF;
            result = sat ? LO : (~acc_reg[COEFF_WIDTH-1:0] + 1'b1);
        end
    end

endmodule

### hdl/shd_index.sv
// ----------------------------------------------------------------------------
// shd_index
// Degree and order tracking in storage order, with range repair and the
// last mark of the coefficient set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shd_index #(
    parameter int MAX_DEGREE = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [shd_pkg::DEG_W-1:0]   degree_limit,
    input  logic                        zonal_only,
    output shd_pkg::idx_tag_t           tag
);

    localparam int DW = shd_pkg::DEG_W;
    localparam int OW = shd_pkg::ORD_W;

    logic [DW-1:0] deg_reg, deg_next;
    logic [OW-1:0] ord_reg, ord_next;

    logic [DW-1:0] lim;
    logic [OW-1:0] lim_x, ord_abs;
    logic          bad;
    logic [DW-1:0] l;
    logic [OW-1:0] m;
    logic [OW:0]   nm_wide;

    assign lim = (int'(degree_limit) > MAX_DEGREE) ? DW'(MAX_DEGREE) : degree_limit;
    assign lim_x   = {1'b0, lim};
    assign ord_abs = ord_reg[OW-1] ? (~ord_reg + 1'b1) : ord_reg;

    assign bad = ({1'b0, deg_reg} > lim_x) || (ord_abs > lim_x) ||
                 ({1'b0, deg_reg} < ord_abs) || (zonal_only && (ord_reg != '0));

    assign l = bad ? '0 : deg_reg;
    assign m = bad ? '0 : ord_reg;

    assign nm_wide = {m[OW-1], m} + 1'b1;

    always_comb
    begin
        ord_next = m;
        deg_next = l;
        if (l < lim)
        begin
            deg_next = l + 1'b1;
            ord_next = m;
        end
        else if (zonal_only)
        begin
            deg_next = '0;
            ord_next = '0;
        end
        else
        begin
            // past the top of a non-negative order: wrap to -L
            if (!m[OW-1] && ($signed(nm_wide) > $signed({1'b0, lim_x})))
                ord_next = (lim == '0) ? '0 : (~lim_x + 1'b1);
            else
                ord_next = nm_wide[OW-1:0];
            deg_next = ord_next[OW-1] ? DW'(~ord_next + 1'b1) : DW'(ord_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= '0;
            ord_reg <= '0;
        end
        else if (advance)
        begin
            deg_reg <= deg_next;
            ord_reg <= ord_next;
        end
    end

    assign tag.degree = l;
    assign tag.order  = m;
    assign tag.last   = (deg_next == '0) && (ord_next == '0);

endmodule

### hdl/sph_harmonic_diag_operator.sv
// ----------------------------------------------------------------------------
// sph_harmonic_diag_operator
// Diagonal operators on complex spherical-harmonic coefficients.
// ----------------------------------------------------------------------------
// Each word is one complex coefficient in storage order; the block tags it
// with its degree, order and last mark and applies the azimuthal derivative,
// the Laplacian, the inverse Laplacian or a pass-through. Both parts run in
// parallel on two lanes of a one-bit-per-cycle shift-add / restoring-divide
// unit. A multiplying operation takes 12 shift-add steps per word over the
// multiplier bits of l(l+1) or m. The inverse Laplacian takes COEFF_WIDTH
// restoring-divide steps, one quotient bit per cycle; at degree 0 it skips
// the steps and gives zero. A result register holds the finished word so
// the next word can be accepted while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_harmonic_diag_operator #(
    parameter int MAX_DEGREE  = 63,
    parameter int COEFF_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [shd_pkg::DEG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COEFF_WIDTH-1:0]     coeff_re,
    input  logic signed [COEFF_WIDTH-1:0]     coeff_im,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COEFF_WIDTH-1:0]     out_re,
    output logic signed [COEFF_WIDTH-1:0]     out_im,
    output logic [shd_pkg::DEG_W-1:0]         degree,
    output logic [shd_pkg::ORD_W-1:0]         order,
    output logic                              last,
    output logic                              saturated
);

    localparam int KW = shd_pkg::KMAG_W;
    localparam int DW = shd_pkg::DEG_W;
    localparam int OW = shd_pkg::ORD_W;
    localparam int CW = $clog2(COEFF_WIDTH + 1);

    logic [DW-1:0] degree_limit_reg;
    logic          zonal_only_reg;
    logic [1:0]    operation_reg;

    shd_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [KW-1:0]      kshift_reg;
    shd_pkg::idx_tag_t  tag_reg;
    shd_pkg::idx_tag_t  cur_tag;
    shd_pkg::lane_ctrl_t ctrl;

    logic                   out_valid_reg;
    logic [COEFF_WIDTH-1:0] out_re_reg, out_im_reg;
    logic                   sat_reg;

    logic                   accept, load_out;
    shd_pkg::op_t           op;
    logic signed [COEFF_WIDTH-1:0] src_a, src_b;
    logic                   kneg_a, kneg_b, acc_div, acc_zero;
    logic [KW-1:0]          acc_kmag, lprod;
    logic [OW-1:0]          m_abs;
    logic signed [COEFF_WIDTH-1:0] res_a, res_b;
    logic                   sat_a, sat_b;

    assign in_ready = (state_reg == shd_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_limit_reg <= '0;
            zonal_only_reg   <= 1'b0;
            operation_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                shd_pkg::REG_DEGREE_LIMIT: degree_limit_reg <= cfg_data;
                shd_pkg::REG_ZONAL_ONLY:   zonal_only_reg   <= cfg_data[0];
                shd_pkg::REG_OPERATION:    operation_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    shd_index #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .degree_limit (degree_limit_reg),
        .zonal_only   (zonal_only_reg),
        .tag          (cur_tag)
    );

    // operand setup for the word being accepted
    assign op    = shd_pkg::op_t'(operation_reg);
    assign m_abs = cur_tag.order[OW-1] ? (~cur_tag.order + 1'b1) : cur_tag.order;
    assign lprod = KW'({{(KW-DW){1'b0}}, cur_tag.degree} *
                       ({{(KW-DW){1'b0}}, cur_tag.degree} + 1'b1));

    always_comb
    begin
        src_a    = coeff_re;
        src_b    = coeff_im;
        kneg_a   = 1'b0;
        kneg_b   = 1'b0;
        acc_div  = 1'b0;
        acc_zero = 1'b0;
        acc_kmag = KW'(1);
        case (op)
            shd_pkg::OP_AZIMUTH:
            begin
                // re' = -m * im, im' = m * re
                src_a    = coeff_im;
                src_b    = coeff_re;
                acc_kmag = KW'(m_abs);
                kneg_a   = !cur_tag.order[OW-1];
                kneg_b   = cur_tag.order[OW-1];
            end
            shd_pkg::OP_LAPLACE:
            begin
                acc_kmag = lprod;
                kneg_a   = 1'b1;
                kneg_b   = 1'b1;
            end
            shd_pkg::OP_INV_LAPLACE:
            begin
                acc_kmag = lprod;
                acc_div  = 1'b1;
                acc_zero = (cur_tag.degree == '0);
            end
            shd_pkg::OP_PASS:
            begin
                acc_kmag = KW'(1);
            end
            default:
            begin
                acc_kmag = KW'(1);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        load_out   = 1'b0;
        case (state_reg)
            shd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    ctrl.div  = acc_div;
                    ctrl.zero = acc_zero;
                    cnt_next  = acc_div ? CW'(COEFF_WIDTH) : CW'(KW);
                    if (acc_zero)
                        state_next = shd_pkg::ST_DONE;
                    else if (acc_div)
                        state_next = shd_pkg::ST_DIV;
                    else
                        state_next = shd_pkg::ST_MUL;
                end
            end
            shd_pkg::ST_MUL, shd_pkg::ST_DIV:
            begin
                ctrl.step = 1'b1;
                ctrl.kbit = kshift_reg[0];
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = shd_pkg::ST_DONE;
            end
            shd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = shd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // multiplier bits shift out during multiply; held as divisor in divide
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kshift_reg <= acc_kmag;
            tag_reg    <= cur_tag;
        end
        else if (state_reg == shd_pkg::ST_MUL)
        begin
            kshift_reg <= kshift_reg >> 1;
        end

        if (load_out)
        begin
            out_re_reg <= res_a;
            out_im_reg <= res_b;
            sat_reg    <= sat_a || sat_b;
            degree     <= tag_reg.degree;
            order      <= tag_reg.order;
            last       <= tag_reg.last;
        end
    end

    shd_lane #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) u_lane_re (
        .clk    (clk),
        .ctrl   (ctrl),
        .x      (src_a),
        .kneg   (kneg_a),
        .kmag   (kshift_reg),
        .result (res_a),
        .sat    (sat_a)
    );

    shd_lane #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) u_lane_im (
        .clk    (clk),
        .ctrl   (ctrl),
        .x      (src_b),
        .kneg   (kneg_b),
        .kmag   (kshift_reg),
        .result (res_b),
        .sat    (sat_b)
    );

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign saturated = sat_reg;

endmodule

### hdl/shd_checker.sv
// ----------------------------------------------------------------------------
// shd_checker
// Port-level checks on the spherical-harmonic diagonal operator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sph_harmonic_diag_operator_assert.svh"

module shd_checker #(
    parameter int COEFF_WIDTH = 32
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [COEFF_WIDTH-1:0]     out_re,
    input logic signed [COEFF_WIDTH-1:0]     out_im,
    input logic [shd_pkg::DEG_W-1:0]         degree,
    input logic [shd_pkg::ORD_W-1:0]         order,
    input logic                              last,
    input logic                              saturated
);

    logic [shd_pkg::ORD_W-1:0] ord_abs;

    assign ord_abs = order[shd_pkg::ORD_W-1] ? (~order + 1'b1) : order;

    // stalled result word holds
    `SHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_re) && $stable(out_im) && $stable(degree) &&
        $stable(order) && $stable(last) && $stable(saturated))

    // one word in the lanes at a time: busy right after an accept
    `SHD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // tags always describe a legal (l, m)
    `SHD_ASSERT_IMP(a_tag_legal, out_valid, ord_abs <= {1'b0, degree})

    // degree zero never clips and has order zero
    `SHD_ASSERT_IMP(a_deg0_no_sat, out_valid && (degree == '0), !saturated && (order == '0))

endmodule

bind sph_harmonic_diag_operator shd_checker #(
    .COEFF_WIDTH(COEFF_WIDTH)
) u_shd_checker (.*);

### verif/shd_coeff_checker.sv
// ----------------------------------------------------------------------------
// shd_coeff_checker
// Watches the register port and both word channels of the spherical-harmonic
// diagonal operator. It keeps its own degree/order counters and register
// copies, predicts each result word on input accept, and compares every
// accepted result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shd_coeff_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [shd_pkg::DEG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [31:0]                coeff_re,
    input  logic signed [31:0]                coeff_im,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [31:0]                out_re,
    input  logic signed [31:0]                out_im,
    input  logic [shd_pkg::DEG_W-1:0]         degree,
    input  logic [shd_pkg::ORD_W-1:0]         order,
    input  logic                              last,
    input  logic                              saturated,
    output int                                mismatch_count,
    output int                                words_pending
);

    localparam int DW = shd_pkg::DEG_W;
    localparam int OW = shd_pkg::ORD_W;

    localparam logic signed [31:0] POS_RAIL = 32'sh7fff_ffff;
    localparam logic signed [31:0] NEG_RAIL = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [DW-1:0]      degree;
        logic [OW-1:0]      order;
        logic               last;
        logic               sat;
    } shd_word_t;

    // register copies and coefficient position
    logic [DW-1:0]        deg_limit;
    logic                 zonal;
    shd_pkg::op_t         op_mode;
    logic [DW-1:0]        deg_cnt;
    logic signed [OW-1:0] ord_cnt;

    shd_word_t expected_words[$];
    shd_word_t want_word;

    initial mismatch_count = 0;

    // returns {clipped, value}
    function automatic logic [32:0] saturate_q(input longint v);
        if (v > longint'(POS_RAIL))
            return {1'b1, POS_RAIL};
        if (v < longint'(NEG_RAIL))
            return {1'b1, NEG_RAIL};
        return {1'b0, v[31:0]};
    endfunction

    // transforms one coefficient at the current position and advances it
    function automatic shd_word_t apply_operator(input logic signed [31:0] re,
                                                 input logic signed [31:0] im);
        shd_word_t w;
        int     lim;
        int     l;
        int     m;
        int     am;
        int     nl;
        int     nm;
        longint k;
        longint pre;
        longint pim;
        logic   clip_re;
        logic   clip_im;

        lim = deg_limit;
        l   = deg_cnt;
        m   = ord_cnt;
        am  = (m < 0) ? -m : m;
        // stale position after a register change restarts at (0,0)
        if (l > lim || am > lim || l < am || (zonal && m != 0))
        begin
            l = 0;
            m = 0;
        end

        case (op_mode)
            shd_pkg::OP_AZIMUTH:
            begin
                pre = -longint'(m) * longint'(im);
                pim = longint'(m) * longint'(re);
            end
            shd_pkg::OP_LAPLACE:
            begin
                k   = -longint'(l) * longint'(l + 1);
                pre = k * longint'(re);
                pim = k * longint'(im);
            end
            shd_pkg::OP_INV_LAPLACE:
            begin
                if (l == 0)
                begin
                    pre = 0;
                    pim = 0;
                end
                else
                begin
                    k   = longint'(l) * longint'(l + 1);
                    pre = -(longint'(re) / k);
                    pim = -(longint'(im) / k);
                end
            end
            default:
            begin
                pre = re;
                pim = im;
            end
        endcase
        {clip_re, w.re} = saturate_q(pre);
        {clip_im, w.im} = saturate_q(pim);
        w.sat = clip_re | clip_im;

        // storage order: m=0, then m=1..L, then m=-L..-1
        if (l < lim)
        begin
            nl = l + 1;
            nm = m;
        end
        else if (zonal)
        begin
            nl = 0;
            nm = 0;
        end
        else if (m >= 0)
        begin
            nm = m + 1;
            if (nm > lim)
                nm = (lim == 0) ? 0 : -lim;
            nl = (nm < 0) ? -nm : nm;
        end
        else
        begin
            nm = m + 1;
            nl = (nm < 0) ? -nm : nm;
        end

        w.degree = l[DW-1:0];
        w.order  = m[OW-1:0];
        w.last   = (nl == 0 && nm == 0);
        deg_cnt  = nl[DW-1:0];
        ord_cnt  = nm[OW-1:0];
        return w;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_limit = '0;
            zonal     = 1'b0;
            op_mode   = shd_pkg::OP_AZIMUTH;
            deg_cnt   = '0;
            ord_cnt   = '0;
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    shd_pkg::REG_DEGREE_LIMIT: deg_limit = cfg_data;
                    shd_pkg::REG_ZONAL_ONLY:   zonal     = cfg_data[0];
                    shd_pkg::REG_OPERATION:    op_mode   = shd_pkg::op_t'(cfg_data[1:0]);
                    default:                   ;
                endcase
            end
            if (in_valid && in_ready)
                expected_words.push_back(apply_operator(coeff_re, coeff_im));
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    note_mismatch("result word with nothing outstanding, out_re", out_re, 0);
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (out_re !== want_word.re)
                        note_mismatch("out_re", out_re, want_word.re);
                    if (out_im !== want_word.im)
                        note_mismatch("out_im", out_im, want_word.im);
                    if (degree !== want_word.degree)
                        note_mismatch("degree", degree, want_word.degree);
                    if (order !== want_word.order)
                        note_mismatch("order (7-bit code)", order, want_word.order);
                    if (last !== want_word.last)
                        note_mismatch("last", last, want_word.last);
                    if (saturated !== want_word.sat)
                        note_mismatch("saturated", saturated, want_word.sat);
                end
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

### verif/sph_harmonic_diag_operator_tb.sv
// ----------------------------------------------------------------------------
// sph_harmonic_diag_operator_tb
// Drives coefficient sets through the diagonal operator under all four
// operation codes, full and zonal layouts, and degree limits from 0 to 63.
// A short directed pass hits the corner values and the stale-position
// restarts; random register settings and mostly whole coefficient sets follow,
// with random idle and stall bursts. Checking lives in shd_coeff_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_harmonic_diag_operator_tb;

    localparam int         DW             = shd_pkg::DEG_W;
    localparam int         OW             = shd_pkg::ORD_W;
    localparam logic [1:0] REG_SPARE      = 2'd3;   // unmapped register index
    localparam int         RANDOM_WORDS   = 1650;
    localparam int         QUIET_TAIL     = 150;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 60;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [DW-1:0]         cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic signed [31:0]    coeff_re  = '0;
    logic signed [31:0]    coeff_im  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [31:0]    out_re;
    logic signed [31:0]    out_im;
    logic [DW-1:0]         degree;
    logic [OW-1:0]         order;
    logic                  last;
    logic                  saturated;

    int                    mismatch_count;
    int                    words_pending;

    logic                  tx_gaps   = 1'b0;
    logic                  rx_stalls = 1'b0;
    int                    words_sent    = 0;
    int                    settings_used = 0;
    logic [3:0]            ops_hit       = '0;
    int                    idle_cycles   = 0;

    always #5 clk = ~clk;

    sph_harmonic_diag_operator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coeff_re  (coeff_re),
        .coeff_im  (coeff_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_re    (out_re),
        .out_im    (out_im),
        .degree    (degree),
        .order     (order),
        .last      (last),
        .saturated (saturated)
    );

    shd_coeff_checker coeff_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .coeff_re       (coeff_re),
        .coeff_im       (coeff_im),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_re         (out_re),
        .out_im         (out_im),
        .degree         (degree),
        .order          (order),
        .last           (last),
        .saturated      (saturated),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // result side: random out_ready stall bursts while rx_stalls is set
    always
    begin
        @(posedge clk);
        if (rx_stalls && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d words outstanding",
                         WATCHDOG_LIMIT, words_pending);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] corner_coeff(input int idx);
        case (idx % 8)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return 32'sh0000_0001;
            4:       return 32'shffff_ffff;
            5:       return 32'sh0001_0000;
            6:       return 32'shffff_0000;
            default: return 32'sh8000_0001;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return corner_coeff($urandom_range(0, 7));
            1, 2:    return int'($urandom_range(0, 131071)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic signed [31:0] re, input logic signed [31:0] im);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            coeff_re <= $urandom;
            coeff_im <= $urandom;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        coeff_re <= re;
        coeff_im <= im;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // hold the sender until every outstanding result word is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input int lim, input logic zonal, input shd_pkg::op_t op);
        logic [DW-1:0] junk;
        wait_drained();
        junk = $urandom;
        cfg_write(shd_pkg::REG_DEGREE_LIMIT, lim[DW-1:0]);
        cfg_write(shd_pkg::REG_ZONAL_ONLY, {junk[DW-1:1], zonal});
        cfg_write(shd_pkg::REG_OPERATION, {junk[DW-1:2], op});
        cfg_we <= 1'b0;
        settings_used++;
        ops_hit[op] = 1'b1;
    endtask

    task automatic send_corners(input int count);
        for (int i = 0; i < count; i++)
            send_word(corner_coeff(words_sent), corner_coeff(words_sent + 3));
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(pick_coeff(), pick_coeff());
    endtask

    initial
    begin
        int           lim;
        logic         zonal;
        shd_pkg::op_t op;
        int           set_len;
        int           count;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: degree limit 0, the set is the lone (0,0) word
        send_corners(1);
        load_settings(2, 1'b0, shd_pkg::OP_AZIMUTH);
        send_corners(9);
        load_settings(3, 1'b1, shd_pkg::OP_INV_LAPLACE);
        send_corners(4);
        wait_drained();
        cfg_write(REG_SPARE, 6'h3f);
        load_settings(1, 1'b0, shd_pkg::OP_PASS);
        send_corners(2);
        // shrink the degree limit mid-set, then go zonal at a nonzero order
        load_settings(3, 1'b0, shd_pkg::OP_LAPLACE);
        send_corners(6);
        load_settings(1, 1'b0, shd_pkg::OP_LAPLACE);
        send_corners(2);
        load_settings(1, 1'b1, shd_pkg::OP_AZIMUTH);
        send_corners(1);

        // largest degree, zonal so the set stays short
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        load_settings(63, 1'b1, shd_pkg::OP_LAPLACE);
        send_random(64);

        while (words_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: lim = $urandom_range(0, 5);
                7, 8:                lim = $urandom_range(6, 20);
                default:             lim = $urandom_range(0, 1) ? 63 : $urandom_range(21, 62);
            endcase
            zonal = ($urandom_range(0, 2) == 0);
            op    = shd_pkg::op_t'($urandom_range(0, 3));
            if (words_sent > RANDOM_WORDS - QUIET_TAIL)
            begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            else
            begin
                tx_gaps   = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            load_settings(lim, zonal, op);
            set_len = zonal ? lim + 1 : (lim + 1) * (lim + 1);
            if ($urandom_range(0, 4) != 0)
            begin
                count = set_len * $urandom_range(1, 3);
                if (count > 300)
                    count = $urandom_range(100, 300);
            end
            else
            begin
                count = $urandom_range(1, 12);
            end
            if (count > RANDOM_WORDS - words_sent)
                count = RANDOM_WORDS - words_sent;
            send_random(count);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d coefficient words under %0d register settings", words_sent,
                 settings_used);
        $display("operation codes used: %b, degree limits 0 through 63, zonal and full",
                 ops_hit);
        if (mismatch_count == 0 && words_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sph_harmonic_diag_operator.f
+incdir+hdl
hdl/shd_pkg.sv
hdl/shd_lane.sv
hdl/shd_index.sv
hdl/sph_harmonic_diag_operator.sv
hdl/shd_checker.sv
verif/shd_coeff_checker.sv
verif/sph_harmonic_diag_operator_tb.sv
